FILE: rtl/core/topological_sort_engine_unit_defines.svh
// assertion macros shared by the checker of the topological sort engine
// no dependencies; include by bare file name
`ifndef TOPOLOGICAL_SORT_ENGINE_UNIT_DEFINES_SVH
`define TOPOLOGICAL_SORT_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define TSE_ASSERT_NOW(label, clock, rst_n, cond, expr) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define TSE_ASSERT_NEXT(label, clock, rst_n, cond, expr) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("next-cycle check failed");

`endif

FILE: rtl/core/tse_pkg.sv
// types and constants of the topological sort engine
// no dependencies
package tse_pkg;

	localparam int VERTEX_W = 5;
	localparam int CFG_W    = 6;

	localparam logic             OP_ADD   = 1'b0;
	localparam logic             OP_RUN   = 1'b1;
	localparam logic [CFG_W-1:0] VC_RESET = 6'd32;

	typedef struct packed {
		logic                operation;
		logic [VERTEX_W-1:0] edge_from;
		logic [VERTEX_W-1:0] edge_to;
	} in_item_t;

	typedef struct packed {
		logic [VERTEX_W-1:0] vertex;
		logic                is_verdict;
		logic                acyclic;
		logic                overflow;
		logic                last;
	} out_item_t;

	// strobes of a generic ram port pair
	typedef struct packed {
		logic we;
		logic re;
	} ram_ctrl_t;

	// strobes of the in-degree store
	typedef struct packed {
		logic rd;
		logic wr;
		logic clear;
	} deg_ctrl_t;

endpackage

FILE: rtl/core/tse_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module tse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/tse_deg_store.sv
// in-degree store: ram with per-vertex valid bits, invalid entries read as zero
// depends on tse_pkg and tse_ram
module tse_deg_store #(
	parameter int MAX_VERTICES = 32,
	parameter int MAX_EDGES    = 256,
	localparam int VW = $clog2(MAX_VERTICES),
	localparam int DW = $clog2(MAX_EDGES + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tse_pkg::deg_ctrl_t ctrl,
	input  logic [VW-1:0]      raddr,
	input  logic [VW-1:0]      waddr,
	input  logic [DW-1:0]      wdata,
	output logic [DW-1:0]      rdata
);
	import tse_pkg::*;

	logic [MAX_VERTICES-1:0] valid_q;
	logic                    rd_vld_q;
	logic [DW-1:0]           ram_rdata;

	tse_ram #(
		.WIDTH(DW),
		.DEPTH(MAX_VERTICES)
	) u_ram (
		.clk  (clk),
		.we   (ctrl.wr),
		.waddr(waddr),
		.wdata(wdata),
		.re   (ctrl.rd),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// whole store clears at once through the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctrl.clear) begin
				valid_q <= '0;
			end else if (ctrl.wr) begin
				valid_q[waddr] <= 1'b1;
			end
			if (ctrl.rd) begin
				rd_vld_q <= valid_q[raddr];
			end
		end
	end

	assign rdata = rd_vld_q ? ram_rdata : '0;

endmodule

FILE: rtl/core/tse_sequencer.sv
// sequencer of the topological sort: edge loading, ready queue and edge walk
// depends on tse_pkg; drives the edge store, ready fifo and in-degree store
module tse_sequencer #(
	parameter int MAX_VERTICES = 32,
	parameter int MAX_EDGES    = 256,
	localparam int VW  = $clog2(MAX_VERTICES),
	localparam int VCW = $clog2(MAX_VERTICES + 1),
	localparam int AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
	localparam int EW  = $clog2(MAX_EDGES + 1),
	localparam int DW  = EW,
	localparam int ED_W = 2 * tse_pkg::VERTEX_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [VCW-1:0]     n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tse_pkg::in_item_t  in_data,
	output logic               res_valid,
	input  logic               res_ready,
	output tse_pkg::out_item_t res_data,
	output tse_pkg::ram_ctrl_t edge_ctrl,
	output logic [AW-1:0]      edge_waddr,
	output logic [ED_W-1:0]    edge_wdata,
	output logic [AW-1:0]      edge_raddr,
	input  logic [ED_W-1:0]    edge_rdata,
	output tse_pkg::ram_ctrl_t fifo_ctrl,
	output logic [VW-1:0]      fifo_waddr,
	output logic [VW-1:0]      fifo_wdata,
	output logic [VW-1:0]      fifo_raddr,
	input  logic [VW-1:0]      fifo_rdata,
	output tse_pkg::deg_ctrl_t deg_ctrl,
	output logic [VW-1:0]      deg_raddr,
	output logic [VW-1:0]      deg_waddr,
	output logic [DW-1:0]      deg_wdata,
	input  logic [DW-1:0]      deg_rdata
);
	import tse_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE     = 11'b000_0000_0001,
		S_ADD_RD   = 11'b000_0000_0010,
		S_ADD_WR   = 11'b000_0000_0100,
		S_SCAN_RD  = 11'b000_0000_1000,
		S_SCAN_CHK = 11'b000_0001_0000,
		S_POP_RD   = 11'b000_0010_0000,
		S_POP_EMIT = 11'b000_0100_0000,
		S_EDGE_RD  = 11'b000_1000_0000,
		S_EDGE_CHK = 11'b001_0000_0000,
		S_DEG_UPD  = 11'b010_0000_0000,
		S_VERDICT  = 11'b100_0000_0000
	} state_t;

	state_t         state_q, state_d;
	logic [EW-1:0]  edges_q, edges_d;
	logic           dropped_q, dropped_d;
	logic [VCW-1:0] idx_q, idx_d;
	logic [VCW-1:0] head_q, head_d;
	logic [VCW-1:0] tail_q, tail_d;
	logic [EW-1:0]  e_q, e_d;
	logic [VW-1:0]  cur_q, cur_d;
	logic [VW-1:0]  tgt_q, tgt_d;
	logic [VW-1:0]  to_q, to_d;

	logic                in_fire;
	logic                add_drop;
	logic [DW-1:0]       deg_next;
	logic [VERTEX_W-1:0] ed_src;
	logic [VERTEX_W-1:0] ed_tgt;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign add_drop = (edges_q == EW'(MAX_EDGES))
		|| (7'(in_data.edge_from) >= 7'(MAX_VERTICES))
		|| (7'(in_data.edge_to) >= 7'(MAX_VERTICES));

	assign ed_src = edge_rdata[ED_W-1:VERTEX_W];
	assign ed_tgt = edge_rdata[VERTEX_W-1:0];

	// shared degree adder: +1 when loading an edge, -1 when walking one
	assign deg_next = deg_rdata + ((state_q == S_ADD_WR) ? DW'(1) : {DW{1'b1}});

	always_comb begin
		state_d   = state_q;
		edges_d   = edges_q;
		dropped_d = dropped_q;
		idx_d     = idx_q;
		head_d    = head_q;
		tail_d    = tail_q;
		e_d       = e_q;
		cur_d     = cur_q;
		tgt_d     = tgt_q;
		to_d      = to_q;

		edge_ctrl  = '0;
		edge_waddr = edges_q[AW-1:0];
		edge_wdata = {in_data.edge_from, in_data.edge_to};
		edge_raddr = e_q[AW-1:0];
		fifo_ctrl  = '0;
		fifo_waddr = tail_q[VW-1:0];
		fifo_wdata = tgt_q;
		fifo_raddr = head_q[VW-1:0];
		deg_ctrl   = '0;
		deg_raddr  = to_q;
		deg_waddr  = to_q;
		deg_wdata  = deg_next;

		res_valid = 1'b0;
		res_data  = '0;

		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (in_data.operation == OP_RUN) begin
						idx_d   = '0;
						head_d  = '0;
						tail_d  = '0;
						state_d = S_SCAN_RD;
					end else if (add_drop) begin
						dropped_d = 1'b1;
					end else begin
						edge_ctrl.we = 1'b1;
						edges_d      = edges_q + EW'(1);
						to_d         = VW'(in_data.edge_to);
						state_d      = S_ADD_RD;
					end
				end
			end
			S_ADD_RD: begin
				deg_ctrl.rd = 1'b1;
				state_d     = S_ADD_WR;
			end
			S_ADD_WR: begin
				deg_ctrl.wr = 1'b1;
				state_d     = S_IDLE;
			end
			S_SCAN_RD: begin
				deg_raddr = idx_q[VW-1:0];
				if (idx_q < n) begin
					deg_ctrl.rd = 1'b1;
					state_d     = S_SCAN_CHK;
				end else begin
					state_d = S_POP_RD;
				end
			end
			S_SCAN_CHK: begin
				fifo_wdata = idx_q[VW-1:0];
				if (deg_rdata == '0) begin
					fifo_ctrl.we = 1'b1;
					tail_d       = tail_q + VCW'(1);
				end
				idx_d   = idx_q + VCW'(1);
				state_d = S_SCAN_RD;
			end
			S_POP_RD: begin
				if (head_q < tail_q) begin
					fifo_ctrl.re = 1'b1;
					head_d       = head_q + VCW'(1);
					state_d      = S_POP_EMIT;
				end else begin
					state_d = S_VERDICT;
				end
			end
			S_POP_EMIT: begin
				res_valid       = 1'b1;
				res_data.vertex = VERTEX_W'(fifo_rdata);
				if (res_ready) begin
					cur_d   = fifo_rdata;
					e_d     = '0;
					state_d = S_EDGE_RD;
				end
			end
			S_EDGE_RD: begin
				if (e_q < edges_q) begin
					edge_ctrl.re = 1'b1;
					state_d      = S_EDGE_CHK;
				end else begin
					state_d = S_POP_RD;
				end
			end
			S_EDGE_CHK: begin
				deg_raddr = VW'(ed_tgt);
				if (7'(ed_src) == 7'(cur_q)) begin
					deg_ctrl.rd = 1'b1;
					tgt_d       = VW'(ed_tgt);
					state_d     = S_DEG_UPD;
				end else begin
					e_d     = e_q + EW'(1);
					state_d = S_EDGE_RD;
				end
			end
			S_DEG_UPD: begin
				deg_waddr = tgt_q;
				if (deg_rdata != '0) begin
					deg_ctrl.wr = 1'b1;
					// target reaches zero: queue it if it is in the graph
					if ((deg_rdata == DW'(1)) && (7'(tgt_q) < 7'(n))) begin
						fifo_ctrl.we = 1'b1;
						tail_d       = tail_q + VCW'(1);
					end
				end
				e_d     = e_q + EW'(1);
				state_d = S_EDGE_RD;
			end
			S_VERDICT: begin
				res_valid           = 1'b1;
				res_data.is_verdict = 1'b1;
				res_data.acyclic    = (tail_q == n);
				res_data.overflow   = dropped_q;
				res_data.last       = 1'b1;
				if (res_ready) begin
					deg_ctrl.clear = 1'b1;
					edges_d        = '0;
					dropped_d      = 1'b0;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			edges_q   <= '0;
			dropped_q <= 1'b0;
			idx_q     <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			e_q       <= '0;
		end else begin
			state_q   <= state_d;
			edges_q   <= edges_d;
			dropped_q <= dropped_d;
			idx_q     <= idx_d;
			head_q    <= head_d;
			tail_q    <= tail_d;
			e_q       <= e_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		tgt_q <= tgt_d;
		to_q  <= to_d;
	end

endmodule

FILE: rtl/core/topological_sort_engine_unit.sv
// top level of the topological sort engine (kahn's algorithm over an edge store)
// depends on tse_pkg, tse_ram, tse_deg_store and tse_sequencer
//
// Edges are loaded one transaction at a time with operation add; a run transaction
// (operation run) sorts the vertices 0..n-1, where n is the vertex_count register
// clipped to MAX_VERTICES, and returns one vertex transaction per ordered vertex
// followed by a verdict transaction with last set. Successors are visited in the
// order their edges were loaded. An accepted edge is handled as an edge store
// write, then a read-modify-write of its target's in-degree through the registered
// read of the degree ram, and no new transaction is taken until that write is done;
// a dropped edge is taken in idle and only sets the overflow flag. A run scans the
// in-degrees of vertices 0..n-1, queueing each zero one in the ready fifo, then per
// ordered vertex pops the ready fifo, emits the vertex and walks every stored edge,
// decrementing the in-degree of each matching target; a final fifo check leads to
// the verdict; back-pressure stalls the run. in_ready is low for the whole run.
// After the verdict the edge count and overflow flag are reset and the in-degrees
// are cleared at once through valid bits, so there is no clearing pass.
// vertex_count may be written only while the block is idle.
module topological_sort_engine_unit #(
	parameter int MAX_VERTICES = 32,
	parameter int MAX_EDGES    = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [tse_pkg::CFG_W-1:0]    cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  tse_pkg::in_item_t            in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output tse_pkg::out_item_t           out_data
);
	import tse_pkg::*;

	localparam int VW   = $clog2(MAX_VERTICES);
	localparam int VCW  = $clog2(MAX_VERTICES + 1);
	localparam int AW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int DW   = $clog2(MAX_EDGES + 1);
	localparam int ED_W = 2 * VERTEX_W;

	// configuration register
	logic [CFG_W-1:0] vertex_count_q;
	logic [VCW-1:0]   n_vert;

	// output register between the sequencer and the result channel
	logic      out_valid_q;
	out_item_t out_q;
	logic      res_valid;
	logic      res_ready;
	out_item_t res_data;

	// edge store: source in the upper half, target in the lower half
	ram_ctrl_t        edge_ctrl;
	logic [AW-1:0]    edge_waddr;
	logic [ED_W-1:0]  edge_wdata;
	logic [AW-1:0]    edge_raddr;
	logic [ED_W-1:0]  edge_rdata;

	// ready fifo of zero in-degree vertices
	ram_ctrl_t        fifo_ctrl;
	logic [VW-1:0]    fifo_waddr;
	logic [VW-1:0]    fifo_wdata;
	logic [VW-1:0]    fifo_raddr;
	logic [VW-1:0]    fifo_rdata;

	// in-degree store
	deg_ctrl_t        deg_ctrl;
	logic [VW-1:0]    deg_raddr;
	logic [VW-1:0]    deg_waddr;
	logic [DW-1:0]    deg_wdata;
	logic [DW-1:0]    deg_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VC_RESET;
		end else if (cfg_wr_en) begin
			vertex_count_q <= cfg_wr_data;
		end
	end

	// vertex counts above the store size saturate
	always_comb begin
		if (7'(vertex_count_q) > 7'(MAX_VERTICES)) begin
			n_vert = VCW'(MAX_VERTICES);
		end else begin
			n_vert = VCW'(vertex_count_q);
		end
	end

	// the sequencer may load a new result whenever the register is empty or empties this cycle
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	tse_ram #(
		.WIDTH(ED_W),
		.DEPTH(MAX_EDGES)
	) u_edge_ram (
		.clk  (clk),
		.we   (edge_ctrl.we),
		.waddr(edge_waddr),
		.wdata(edge_wdata),
		.re   (edge_ctrl.re),
		.raddr(edge_raddr),
		.rdata(edge_rdata)
	);

	tse_ram #(
		.WIDTH(VW),
		.DEPTH(MAX_VERTICES)
	) u_fifo_ram (
		.clk  (clk),
		.we   (fifo_ctrl.we),
		.waddr(fifo_waddr),
		.wdata(fifo_wdata),
		.re   (fifo_ctrl.re),
		.raddr(fifo_raddr),
		.rdata(fifo_rdata)
	);

	tse_deg_store #(
		.MAX_VERTICES(MAX_VERTICES),
		.MAX_EDGES   (MAX_EDGES)
	) u_deg_store (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (deg_ctrl),
		.raddr (deg_raddr),
		.waddr (deg_waddr),
		.wdata (deg_wdata),
		.rdata (deg_rdata)
	);

	tse_sequencer #(
		.MAX_VERTICES(MAX_VERTICES),
		.MAX_EDGES   (MAX_EDGES)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.n         (n_vert),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.edge_ctrl (edge_ctrl),
		.edge_waddr(edge_waddr),
		.edge_wdata(edge_wdata),
		.edge_raddr(edge_raddr),
		.edge_rdata(edge_rdata),
		.fifo_ctrl (fifo_ctrl),
		.fifo_waddr(fifo_waddr),
		.fifo_wdata(fifo_wdata),
		.fifo_raddr(fifo_raddr),
		.fifo_rdata(fifo_rdata),
		.deg_ctrl  (deg_ctrl),
		.deg_raddr (deg_raddr),
		.deg_waddr (deg_waddr),
		.deg_wdata (deg_wdata),
		.deg_rdata (deg_rdata)
	);

endmodule

FILE: rtl/core/tse_checker.sv
// port-level checker of the topological sort engine, bound to the top level
// depends on tse_pkg and topological_sort_engine_unit_defines.svh
`include "topological_sort_engine_unit_defines.svh"

module tse_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input tse_pkg::in_item_t         in_data,
	input logic                      out_valid,
	input logic                      out_ready,
	input tse_pkg::out_item_t        out_data
);
	import tse_pkg::*;

	// a stalled result holds
	`TSE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))

	// a run transaction leaves the block busy in the cycle after it is accepted
	`TSE_ASSERT_NEXT(a_busy_after_run, clk, arst_n, in_valid && in_ready && (in_data.operation == OP_RUN), !in_ready)

	// a pending vertex result means the run is still going on
	`TSE_ASSERT_NOW(a_busy_during_run, clk, arst_n, out_valid && !out_data.last, !in_ready)

	// only the verdict carries last, and it names no vertex
	`TSE_ASSERT_NOW(a_verdict_marks, clk, arst_n, out_valid, (out_data.last == out_data.is_verdict) && (!out_data.is_verdict || (out_data.vertex == '0)))

endmodule

bind topological_sort_engine_unit tse_checker u_tse_checker (.*);
